@@ src/mfq_pkg.sv @@
package mfq_pkg;

  // sizes
  localparam int NTHR = 64;
  localparam int NLEV = 64;
  localparam int TW   = 6;
  localparam int LW   = 6;
  localparam int SW   = 9;
  localparam int TMW  = 17;

  typedef logic [TW-1:0] tid_t;
  typedef logic [LW-1:0] lvl_t;
  typedef logic [SW-1:0] slice_t;

  localparam lvl_t LVL_LAST = LW'(NLEV - 1);
  localparam tid_t TID_LAST = TW'(NTHR - 1);

  // request operation codes
  typedef enum logic [1:0] {
    OP_READY    = 2'd0,
    OP_DISARM   = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_GET_NEXT = 2'd3
  } op_t;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_QUEUED    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // config register byte addresses
  localparam logic [3:0] ADDR_INIT_SLICE = 4'd0;
  localparam logic [3:0] ADDR_BOOST_THR  = 4'd4;
  localparam logic [3:0] ADDR_TOP_LEVEL  = 4'd8;

  // datapath steps issued by the controller
  typedef enum logic [4:0] {
    DP_IDLE, DP_LOOK, DP_DEC, DP_PUSH_RD, DP_PUSH_WR,
    DP_UL_A, DP_UL_B, DP_UL_C, DP_UL_D, DP_UL_FIX,
    DP_BS_RD, DP_BS_WR, DP_BL_INIT, DP_BL_T0, DP_BL_RD, DP_BL_WR, DP_BL_END,
    DP_SC, DP_POP_A, DP_POP_B, DP_FIN
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
    logic     latch;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic queued;
    logic known;
    logic has_cur;
    logic boost_now;
    logic boost_pend;
    logic ne_lv;
    logic cur_match;
    logic cur_tail;
    logic cur_last;
    logic lv_last;
    logic pop_last;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ src/mfq_ctrl.sv @@
module mfq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  mfq_pkg::dp_stat_t stat,
  output mfq_pkg::dp_cmd_t  cmd
);
  import mfq_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE    = 21'h000001,
    S_LOOK    = 21'h000002,
    S_DEC     = 21'h000004,
    S_PUSH_RD = 21'h000008,
    S_PUSH_WR = 21'h000010,
    S_UL_A    = 21'h000020,
    S_UL_B    = 21'h000040,
    S_UL_C    = 21'h000080,
    S_UL_D    = 21'h000100,
    S_UL_FIX  = 21'h000200,
    S_BS_RD   = 21'h000400,
    S_BS_WR   = 21'h000800,
    S_BL_INIT = 21'h001000,
    S_BL_T0   = 21'h002000,
    S_BL_RD   = 21'h004000,
    S_BL_WR   = 21'h008000,
    S_BL_END  = 21'h010000,
    S_SC      = 21'h020000,
    S_POP_A   = 21'h040000,
    S_POP_B   = 21'h080000,
    S_FIN     = 21'h100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (s_tvalid) state_next = S_LOOK;
      S_LOOK:    state_next = S_DEC;
      S_DEC: begin
        case (stat.op)
          OP_READY:  state_next = stat.queued ? S_FIN : S_PUSH_RD;
          OP_DISARM: state_next = stat.queued ? S_UL_A : S_FIN;
          OP_REMOVE: state_next = (stat.known && stat.queued) ? S_UL_A : S_FIN;
          default: begin
            if (stat.has_cur && !stat.queued) state_next = S_PUSH_RD;
            else if (stat.boost_now)          state_next = S_BS_RD;
            else                              state_next = S_SC;
          end
        endcase
      end
      S_PUSH_RD: state_next = S_PUSH_WR;
      S_PUSH_WR: begin
        if (stat.op != OP_GET_NEXT) state_next = S_FIN;
        else if (stat.boost_pend)   state_next = S_BS_RD;
        else                        state_next = S_SC;
      end
      S_UL_A:    state_next = S_UL_B;
      S_UL_B:    state_next = S_UL_C;
      S_UL_C: begin
        if (stat.cur_match)     state_next = S_UL_FIX;
        else if (stat.cur_tail) state_next = S_FIN;
        else                    state_next = S_UL_D;
      end
      S_UL_D:    state_next = S_UL_C;
      S_UL_FIX:  state_next = S_FIN;
      S_BS_RD:   state_next = S_BS_WR;
      S_BS_WR:   state_next = stat.cur_last ? S_BL_INIT : S_BS_RD;
      S_BL_INIT: state_next = S_BL_T0;
      S_BL_T0:   state_next = S_BL_RD;
      S_BL_RD: begin
        if (stat.ne_lv)        state_next = S_BL_WR;
        else if (stat.lv_last) state_next = S_BL_END;
      end
      S_BL_WR:   state_next = stat.lv_last ? S_BL_END : S_BL_RD;
      S_BL_END:  state_next = S_SC;
      S_SC: begin
        if (stat.ne_lv)        state_next = S_POP_A;
        else if (stat.lv_last) state_next = S_FIN;
      end
      S_POP_A:   state_next = stat.pop_last ? S_FIN : S_POP_B;
      S_POP_B:   state_next = S_FIN;
      S_FIN:     if (!stat.out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // command to the datapath
  always_comb begin
    cmd.latch    = (state == S_IDLE) && s_tvalid;
    cmd.load_out = (state == S_FIN) && !stat.out_busy;
    unique case (state)
      S_IDLE:    cmd.step = DP_IDLE;
      S_LOOK:    cmd.step = DP_LOOK;
      S_DEC:     cmd.step = DP_DEC;
      S_PUSH_RD: cmd.step = DP_PUSH_RD;
      S_PUSH_WR: cmd.step = DP_PUSH_WR;
      S_UL_A:    cmd.step = DP_UL_A;
      S_UL_B:    cmd.step = DP_UL_B;
      S_UL_C:    cmd.step = DP_UL_C;
      S_UL_D:    cmd.step = DP_UL_D;
      S_UL_FIX:  cmd.step = DP_UL_FIX;
      S_BS_RD:   cmd.step = DP_BS_RD;
      S_BS_WR:   cmd.step = DP_BS_WR;
      S_BL_INIT: cmd.step = DP_BL_INIT;
      S_BL_T0:   cmd.step = DP_BL_T0;
      S_BL_RD:   cmd.step = DP_BL_RD;
      S_BL_WR:   cmd.step = DP_BL_WR;
      S_BL_END:  cmd.step = DP_BL_END;
      S_SC:      cmd.step = DP_SC;
      S_POP_A:   cmd.step = DP_POP_A;
      S_POP_B:   cmd.step = DP_POP_B;
      S_FIN:     cmd.step = DP_FIN;
      default:   cmd.step = DP_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

endmodule

@@ src/mfq_dpath.sv @@
module mfq_dpath (
  input  logic              clk,
  input  logic              rst,
  input  mfq_pkg::dp_cmd_t  cmd,
  output mfq_pkg::dp_stat_t stat,
  input  logic [1:0]        operation,
  input  logic [5:0]        thread_id,
  input  logic              is_new,
  input  logic              has_current,
  input  logic              preemptive,
  input  logic [7:0]        initial_slice,
  input  logic [15:0]       boost_threshold,
  input  logic [5:0]        top_normal_level,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              next_valid,
  output logic [5:0]        next_thread,
  output logic [1:0]        status,
  output logic              boosted
);
  import mfq_pkg::*;

  // latched request
  op_t  op_q;
  tid_t tid;
  logic fresh, hc, pre;

  // walk registers
  lvl_t lv;
  tid_t cur, prev, tail, t0;
  logic has_prev, boost_p;
  logic [TMW-1:0] timer;

  // result being built
  logic       res_nv, res_bo;
  tid_t       res_nt;
  logic [1:0] res_st;

  // flag vectors
  logic [NTHR-1:0] known, queued, tv;
  logic [NLEV-1:0] ne;

  // memories
  lvl_t   lvl_mem [NTHR];
  slice_t slc_mem [NTHR];
  tid_t   nxt_mem [NTHR];
  tid_t   hd_mem  [NLEV];
  tid_t   tl_mem  [NLEV];

  lvl_t   lvl_raw, lvl_q;
  slice_t slc_raw, slc_q;
  logic   tv_q;
  tid_t   nxt_q, hd_q, tl_q;

  tid_t   lvl_ra, nxt_ra;
  logic   lvl_we, nxt_we, hd_we, tl_we;
  tid_t   lvl_wa, nxt_wa;
  lvl_t   hd_wa, tl_wa;
  lvl_t   lvl_wd;
  slice_t slc_wd;
  tid_t   nxt_wd, hd_wd, tl_wd;

  logic           can_dem, push_need, boost_now, ul_last;
  lvl_t           new_lv;
  slice_t         dem_slice, slice_add;
  logic [TMW-1:0] sum;

  // tables read as zero until written
  assign lvl_q = tv_q ? lvl_raw : '0;
  assign slc_q = tv_q ? slc_raw : '0;

  // demotion and boost timer
  assign new_lv    = lvl_q + 1'b1;
  assign can_dem   = pre && (lvl_q < top_normal_level) && (lvl_q != LVL_LAST);
  assign dem_slice = SW'({new_lv, 1'b0}) + SW'(initial_slice);
  assign push_need = hc && !queued[tid];
  assign slice_add = hc ? slc_q : SW'(initial_slice);
  assign sum       = timer + TMW'(slice_add);
  assign boost_now = (sum >= TMW'(boost_threshold));
  assign ul_last   = (tail == tid);

  assign lvl_ra = (cmd.step == DP_BS_RD) ? cur : tid;
  assign nxt_ra = (cmd.step == DP_POP_A) ? hd_q : cur;

  // memory write selection
  always_comb begin
    lvl_we = 1'b0; lvl_wa = tid; lvl_wd = '0; slc_wd = '0;
    nxt_we = 1'b0; nxt_wa = prev; nxt_wd = nxt_q;
    hd_we  = 1'b0; hd_wa = lv; hd_wd = nxt_q;
    tl_we  = 1'b0; tl_wa = lv; tl_wd = tid;
    case (cmd.step)
      DP_DEC: begin
        case (op_q)
          OP_READY: if (!queued[tid] && fresh) begin
            lvl_we = 1'b1; slc_wd = SW'(initial_slice);
          end
          OP_REMOVE: if (known[tid]) lvl_we = 1'b1;
          OP_GET_NEXT: if (push_need && can_dem) begin
            lvl_we = 1'b1; lvl_wd = new_lv; slc_wd = dem_slice;
          end
          default: ;
        endcase
      end
      DP_PUSH_WR: begin
        if (ne[lv]) begin
          nxt_we = 1'b1; nxt_wa = tl_q; nxt_wd = tid;
        end else begin
          hd_we = 1'b1; hd_wd = tid;
        end
        tl_we = 1'b1;
      end
      DP_UL_FIX: begin
        if (!has_prev) begin
          hd_we = !ul_last;
        end else if (ul_last) begin
          tl_we = 1'b1; tl_wd = prev;
        end else begin
          nxt_we = 1'b1;
        end
      end
      DP_BS_WR: if (queued[cur] && lvl_q != '0) begin
        lvl_we = 1'b1; lvl_wa = cur; slc_wd = SW'(initial_slice);
      end
      DP_BL_WR: begin
        if (ne[0]) begin
          nxt_we = 1'b1; nxt_wa = t0; nxt_wd = hd_q;
        end else begin
          hd_we = 1'b1; hd_wa = '0; hd_wd = hd_q;
        end
      end
      DP_BL_END: begin
        tl_we = ne[0]; tl_wa = '0; tl_wd = t0;
      end
      DP_POP_B: hd_we = 1'b1;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_wa] <= lvl_wd;
      slc_mem[lvl_wa] <= slc_wd;
    end
    lvl_raw <= lvl_mem[lvl_ra];
    slc_raw <= slc_mem[lvl_ra];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_q <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (hd_we) hd_mem[hd_wa] <= hd_wd;
    hd_q <= hd_mem[lv];
  end

  always_ff @(posedge clk) begin
    if (tl_we) tl_mem[tl_wa] <= tl_wd;
    tl_q <= tl_mem[lv];
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      known     <= '0;
      queued    <= '0;
      tv        <= '0;
      ne        <= '0;
      timer     <= '0;
      out_valid <= 1'b0;
      tv_q      <= 1'b0;
    end else begin
      tv_q <= tv[lvl_ra];
      if (lvl_we) tv[lvl_wa] <= 1'b1;
      case (cmd.step)
        DP_DEC: begin
          case (op_q)
            OP_READY:    if (!queued[tid]) known[tid] <= 1'b1;
            OP_REMOVE:   known[tid] <= 1'b0;
            OP_GET_NEXT: begin
              if (push_need) known[tid] <= 1'b1;
              timer <= boost_now ? '0 : sum;
            end
            default: ;
          endcase
        end
        DP_PUSH_WR: begin
          queued[tid] <= 1'b1;
          ne[lv]      <= 1'b1;
        end
        DP_UL_FIX: begin
          queued[tid] <= 1'b0;
          if (!has_prev && ul_last) ne[lv] <= 1'b0;
        end
        DP_BL_WR: begin
          ne[lv] <= 1'b0;
          ne[0]  <= 1'b1;
        end
        DP_POP_A: begin
          queued[hd_q] <= 1'b0;
          if (hd_q == tl_q) ne[lv] <= 1'b0;
        end
        default: ;
      endcase
      if (cmd.load_out)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op_t'(operation);
      tid    <= thread_id;
      fresh  <= is_new;
      hc     <= has_current;
      pre    <= preemptive;
      res_nv <= 1'b0;
      res_nt <= '0;
      res_st <= ST_OK;
      res_bo <= 1'b0;
    end
    case (cmd.step)
      DP_DEC: begin
        cur <= '0;
        case (op_q)
          OP_READY: begin
            if (queued[tid]) res_st <= ST_QUEUED;
            lv <= fresh ? '0 : lvl_q;
          end
          OP_DISARM: begin
            if (!queued[tid]) res_st <= ST_NOT_FOUND;
            lv <= lvl_q;
          end
          OP_REMOVE: begin
            if (!known[tid]) res_st <= ST_NOT_FOUND;
            lv <= lvl_q;
          end
          default: begin
            res_bo  <= boost_now;
            boost_p <= boost_now;
            if (hc && queued[tid]) res_st <= ST_QUEUED;
            lv <= push_need ? (can_dem ? new_lv : lvl_q) : '0;
          end
        endcase
      end
      DP_PUSH_WR: begin
        lv  <= '0;
        cur <= '0;
      end
      DP_UL_B: begin
        cur      <= hd_q;
        tail     <= tl_q;
        has_prev <= 1'b0;
      end
      DP_UL_C: if (cur != tid) begin
        prev     <= cur;
        has_prev <= 1'b1;
      end
      DP_UL_D: cur <= nxt_q;
      DP_BS_WR: begin
        cur <= cur + 1'b1;
        lv  <= '0;
      end
      DP_BL_T0: begin
        t0 <= tl_q;
        lv <= LW'(1);
      end
      DP_BL_RD: if (!ne[lv]) lv <= lv + 1'b1;
      DP_BL_WR: begin
        t0 <= tl_q;
        lv <= lv + 1'b1;
      end
      DP_BL_END: lv <= '0;
      DP_SC:     if (!ne[lv]) lv <= lv + 1'b1;
      DP_POP_A: begin
        res_nv <= 1'b1;
        res_nt <= hd_q;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      next_valid  <= res_nv;
      next_thread <= res_nt;
      status      <= res_st;
      boosted     <= res_bo;
    end
  end

  // status to the controller
  always_comb begin
    stat.op         = op_q;
    stat.queued     = queued[tid];
    stat.known      = known[tid];
    stat.has_cur    = hc;
    stat.boost_now  = boost_now;
    stat.boost_pend = boost_p;
    stat.ne_lv      = ne[lv];
    stat.cur_match  = (cur == tid);
    stat.cur_tail   = (cur == tail);
    stat.cur_last   = (cur == TID_LAST);
    stat.lv_last    = (lv == LVL_LAST);
    stat.pop_last   = (hd_q == tl_q);
    stat.out_busy   = out_valid && !out_ready;
  end

endmodule

@@ src/multilevel_feedback_queue_scheduler_top.sv @@
// Multilevel feedback queue scheduler for 64 threads and 64 levels, one request
// at a time. A request enters on the s_ side when s_tready is high and gives one
// result on the m_ side; the result register lets the next request enter while
// the last result waits. A get next scans the levels for the first one that is
// not empty; disarm and remove walk the level's linked list to find the target;
// a get next that boosts adds a sweep of the thread table and splices the queues
// of the higher levels onto level 0. The link, head and tail memories have
// registered reads, with separate read and write addresses. Registers:
// initial_slice at 0x0, boost_threshold at 0x4, top_normal_level at 0x8;
// write them only while idle.
module multilevel_feedback_queue_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // operation, thread_id, is_new, has_current, preemptive
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // next_valid, next_thread, status, boosted
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mfq_pkg::*;

  logic [7:0]  initial_slice;
  logic [15:0] boost_threshold;
  logic [5:0]  top_normal_level;
  logic [3:0]  reg_addr;
  logic        next_valid, boosted;
  logic [5:0]  next_thread;
  logic [1:0]  status;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready   = 1'b1;
  assign reg_addr = {paddr[3:2], 2'b00};

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_slice    <= 8'd10;
      boost_threshold  <= 16'd1000;
      top_normal_level <= 6'd60;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_addr)
        ADDR_INIT_SLICE: initial_slice    <= pwdata[7:0];
        ADDR_BOOST_THR:  boost_threshold  <= pwdata[15:0];
        ADDR_TOP_LEVEL:  top_normal_level <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // config readback
  always_comb begin
    unique case (reg_addr)
      ADDR_INIT_SLICE: prdata = {24'd0, initial_slice};
      ADDR_BOOST_THR:  prdata = {16'd0, boost_threshold};
      ADDR_TOP_LEVEL:  prdata = {26'd0, top_normal_level};
      default:         prdata = '0;
    endcase
  end

  mfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfq_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (s_tdata[1:0]),
    .thread_id        (s_tdata[7:2]),
    .is_new           (s_tdata[8]),
    .has_current      (s_tdata[9]),
    .preemptive       (s_tdata[10]),
    .initial_slice    (initial_slice),
    .boost_threshold  (boost_threshold),
    .top_normal_level (top_normal_level),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .next_valid       (next_valid),
    .next_thread      (next_thread),
    .status           (status),
    .boosted          (boosted)
  );

  assign m_tdata = {6'd0, boosted, status, next_thread, next_valid};

endmodule
